// ===== design/dd_pkg.sv =====
// dd_pkg: types, constants and calendar tables for the day difference block.
// No dependencies; imported by dd_mul and date_difference_in_days.
package dd_pkg;

	// multiplier operand and product widths
	localparam int unsigned OP_W   = 15;
	localparam int unsigned PROD_W = 2 * OP_W;

	// floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x below 2^15
	localparam logic [OP_W-1:0] RECIP_100   = 15'd20972;
	localparam int unsigned     RECIP_SHIFT = 21;
	localparam logic [OP_W-1:0] DAYS_YEAR   = 15'd365;
	localparam logic [OP_W-1:0] YEAR_BIAS   = 15'd399;

	// day numbers and magnitudes
	localparam int unsigned     DN_W    = 23;
	localparam logic [DN_W-1:0] MAX_MAG = 23'd4194303;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	typedef struct packed {
		logic [4:0]  start_day;
		logic [3:0]  start_month;
		logic [13:0] start_year;
		logic [4:0]  end_day;
		logic [3:0]  end_month;
		logic [13:0] end_year;
		logic        include_end_day;
	} dd_query_t;

	typedef struct packed {
		logic signed [DN_W-1:0] day_difference;
		logic                   invalid_date;
	} dd_answer_t;

	// request to the shared multiplier
	typedef struct packed {
		logic            en;
		logic [OP_W-1:0] a;
		logic [OP_W-1:0] b;
	} dd_mul_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_YEAR_DIV,
		ST_BIAS_DIV,
		ST_BIAS_MUL,
		ST_SUM,
		ST_DIFF
	} dd_state_t;

	// length of a month; leap selects 29 for February
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// days in the year before the first of the month
	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] n;
		case (m)
			4'd1:    n = 9'd0;
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

// ===== design/dd_mul.sv =====
// dd_mul: shared 15 x 15 multiplier with a registered product.
// Depends on dd_pkg for the request struct and widths.
module dd_mul (
	input  logic                      clk,
	input  dd_pkg::dd_mul_req_t       req,
	output logic [dd_pkg::PROD_W-1:0] prod
);
	import dd_pkg::*;

	logic [PROD_W-1:0] prod_q;

	// product lands in the cycle after the request
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= PROD_W'(req.a) * PROD_W'(req.b);
		end
	end

	assign prod = prod_q;

endmodule

// ===== design/date_difference_in_days.sv =====
// date_difference_in_days: signed Gregorian day count between two dates.
// Depends on dd_pkg and the shared multiplier dd_mul.
//
//   channel  | valid         | stall         | payload
//   ---------+---------------+---------------+------------------------
//   query    | query_valid   | query_stall   | query  (dd_query_t)
//   answer   | answer_valid  | answer_stall  | answer (dd_answer_t)
//
// Each transaction runs in steps from acceptance until its answer is loaded:
// four steps per date (year / 100, biased year / 100, biased year * 365 on the
// multiplier, then the sum), for two dates, then a final step for the difference.
// The sequencer then returns to idle and only there takes a new query; the steps
// share the single multiplier. query_stall is high while the sequencer is not idle;
// a held answer keeps the last step waiting until answer_stall drops.
// arst_n clears the sequencer and the answer valid flag.
module date_difference_in_days (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               query_valid,
	output logic               query_stall,
	input  dd_pkg::dd_query_t  query,
	output logic               answer_valid,
	input  logic               answer_stall,
	output dd_pkg::dd_answer_t answer
);
	import dd_pkg::*;

	dd_state_t         state_q, state_d;
	dd_query_t         query_q;
	logic              sel_q;
	logic [7:0]        yq_q;
	logic [7:0]        pq_q;
	logic [DN_W-1:0]   dn_start_q, dn_end_q;
	logic              bad_q;
	logic              answer_valid_q;
	dd_answer_t        answer_q;

	dd_mul_req_t       mul_req;
	logic [PROD_W-1:0] prod;

	logic              accept;
	logic              load_answer;

	logic [4:0]        cur_d;
	logic [3:0]        cur_m;
	logic [13:0]       cur_y;
	logic [OP_W-1:0]   bias_y;
	logic [13:0]       hund;
	logic              leap;
	logic              date_ok;
	logic [DN_W-1:0]   dn;

	logic signed [DN_W:0] diff;
	logic                 neg;
	logic [DN_W-1:0]      mag;
	logic [DN_W:0]        mag_inc;
	logic [DN_W-1:0]      mag_sat;
	logic [DN_W-1:0]      result;

	dd_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	assign accept = query_valid && !query_stall;

	// select the date in work
	always_comb begin
		if (sel_q) begin
			cur_d = query_q.end_day;
			cur_m = query_q.end_month;
			cur_y = query_q.end_year;
		end else begin
			cur_d = query_q.start_day;
			cur_m = query_q.start_month;
			cur_y = query_q.start_year;
		end
	end

	assign bias_y = OP_W'(cur_y) + YEAR_BIAS;

	// leap year and validity from year / 100
	assign hund = 14'({yq_q, 6'b0} + {yq_q, 5'b0} + {yq_q, 2'b0});
	assign leap = (cur_y[1:0] == 2'b00) && ((cur_y != hund) || (yq_q[1:0] == 2'b00));
	assign date_ok = (cur_m >= MONTH_JAN) && (cur_m <= MONTH_DEC) && (cur_d != 5'd0)
		&& (cur_d <= month_len(cur_m, leap));

	// day number: 365p + p/4 - p/100 + p/400 + days before month + leap day + day
	assign dn = DN_W'(prod) + DN_W'(bias_y >> 2) - DN_W'(pq_q) + DN_W'(pq_q >> 2)
		+ DN_W'(days_before(cur_m)) + DN_W'((cur_m > MONTH_FEB) && leap) + DN_W'(cur_d);

	// signed difference, magnitude, end day and saturation
	always_comb begin
		diff    = $signed({1'b0, dn_end_q}) - $signed({1'b0, dn_start_q});
		neg     = diff[DN_W];
		mag     = neg ? DN_W'(-diff) : DN_W'(diff);
		mag_inc = {1'b0, mag} + (DN_W+1)'(query_q.include_end_day);
		mag_sat = (mag_inc > (DN_W+1)'(MAX_MAG)) ? MAX_MAG : mag_inc[DN_W-1:0];
		result  = neg ? (~mag_sat + DN_W'(1)) : mag_sat;
	end

	// sequencer: next state, multiplier requests, stall
	always_comb begin
		state_d     = state_q;
		mul_req.en  = 1'b0;
		mul_req.a   = bias_y;
		mul_req.b   = RECIP_100;
		query_stall = (state_q != ST_IDLE);
		load_answer = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (query_valid) state_d = ST_YEAR_DIV;
			end
			ST_YEAR_DIV: begin
				mul_req.en = 1'b1;
				mul_req.a  = OP_W'(cur_y);
				state_d    = ST_BIAS_DIV;
			end
			ST_BIAS_DIV: begin
				mul_req.en = 1'b1;
				state_d    = ST_BIAS_MUL;
			end
			ST_BIAS_MUL: begin
				mul_req.en = 1'b1;
				mul_req.b  = DAYS_YEAR;
				state_d    = ST_SUM;
			end
			ST_SUM: begin
				state_d = sel_q ? ST_DIFF : ST_YEAR_DIV;
			end
			ST_DIFF: begin
				if (!answer_valid_q || !answer_stall) begin
					load_answer = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
			bad_q <= 1'b0;
		end else if (accept) begin
			sel_q <= 1'b0;
			bad_q <= 1'b0;
		end else if (state_q == ST_SUM) begin
			sel_q <= 1'b1;
			bad_q <= bad_q || !date_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			query_q <= query;
		end
		if (state_q == ST_BIAS_DIV) begin
			yq_q <= prod[RECIP_SHIFT +: 8];
		end
		if (state_q == ST_BIAS_MUL) begin
			pq_q <= prod[RECIP_SHIFT +: 8];
		end
		if (state_q == ST_SUM) begin
			if (sel_q) dn_end_q <= dn;
			else       dn_start_q <= dn;
		end
	end

	// answer register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answer_valid_q <= 1'b0;
		end else if (load_answer) begin
			answer_valid_q <= 1'b1;
		end else if (!answer_stall) begin
			answer_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_answer) begin
			answer_q.day_difference <= bad_q ? '0 : $signed(result);
			answer_q.invalid_date   <= bad_q;
		end
	end

	assign answer_valid = answer_valid_q;
	assign answer       = answer_q;

endmodule

// ===== tb/tb_date_difference_in_days.sv =====
// tb_date_difference_in_days: self-checking testbench for the Gregorian day difference block.
// Depends on dd_pkg and date_difference_in_days; answers are predicted from day-number arithmetic.
`timescale 1ns / 100ps

module tb_date_difference_in_days;
	import dd_pkg::*;

	localparam int unsigned CLK_HALF     = 5;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned N_VALID      = 1000;
	localparam int unsigned N_WIDE       = 200;
	localparam int unsigned N_BAD        = 300;

	localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int unsigned DAYS_AHEAD [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304,
		334};

	typedef enum int unsigned {
		STALL_NONE,
		STALL_HALF,
		STALL_RARE,
		STALL_RUNS
	} stall_mode_t;

	typedef struct {
		dd_query_t  q;
		dd_answer_t a;
	} due_answer_t;

	logic       clk;
	logic       arst_n;
	logic       query_valid;
	logic       query_stall;
	dd_query_t  query;
	logic       answer_valid;
	logic       answer_stall;
	dd_answer_t answer;

	due_answer_t due_answers [$];
	int unsigned error_count;
	int unsigned sent_count;
	int unsigned answer_count;
	int unsigned invalid_count;
	int unsigned saturated_count;
	int unsigned negative_count;
	int unsigned burst_left;
	bit          back_to_back;
	stall_mode_t stall_mode;
	int unsigned stall_span;

	date_difference_in_days dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_stall  (query_stall),
		.query        (query),
		.answer_valid (answer_valid),
		.answer_stall (answer_stall),
		.answer       (answer)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// calendar helpers for the predictor
	function automatic bit is_leap(input int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
	endfunction

	function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
		if (m < 1 || m > 12)
			return 0;
		if (m == 2 && is_leap(y))
			return 29;
		return MONTH_DAYS[m - 1];
	endfunction

	// serial day count, year biased so it stays positive
	function automatic longint day_serial(input int unsigned d, input int unsigned m,
			input int unsigned y);
		longint p;
		longint n;
		p = longint'(y) + 399;
		n = 365 * p + p / 4 - p / 100 + p / 400;
		n += DAYS_AHEAD[m - 1];
		if (m > 2 && is_leap(y))
			n += 1;
		return n + d;
	endfunction

	// expected answer: signed day count, magnitude bumped and saturated, or invalid flag
	function automatic dd_answer_t day_count_answer(input dd_query_t q);
		dd_answer_t   a;
		longint       diff;
		longint       mag;
		bit           neg;
		logic [22:0]  magv;
		a = '0;
		if (q.start_day == 0 || q.start_day > days_in_month(q.start_month, q.start_year) ||
				q.end_day == 0 || q.end_day > days_in_month(q.end_month, q.end_year)) begin
			a.invalid_date = 1'b1;
			return a;
		end
		diff = day_serial(q.end_day, q.end_month, q.end_year) -
			day_serial(q.start_day, q.start_month, q.start_year);
		neg = diff < 0;
		mag = neg ? -diff : diff;
		mag += q.include_end_day;
		if (mag > longint'(MAX_MAG))
			mag = MAX_MAG;
		magv = mag[22:0];
		a.day_difference = neg ? (~magv + 23'd1) : magv;
		return a;
	endfunction

	function automatic dd_query_t make_query(input int unsigned sd, input int unsigned sm,
			input int unsigned sy, input int unsigned ed, input int unsigned em,
			input int unsigned ey, input bit inc);
		dd_query_t q;
		q.start_day       = sd[4:0];
		q.start_month     = sm[3:0];
		q.start_year      = sy[13:0];
		q.end_day         = ed[4:0];
		q.end_month       = em[3:0];
		q.end_year        = ey[13:0];
		q.include_end_day = inc;
		return q;
	endfunction

	// random well-formed date within a year range
	task automatic pick_date(input int unsigned ylo, input int unsigned yhi,
			output int unsigned d, output int unsigned m, output int unsigned y);
		y = $urandom_range(ylo, yhi);
		m = $urandom_range(1, 12);
		d = $urandom_range(1, days_in_month(m, y));
	endtask

	// send one query transaction; bursts with random gaps unless back_to_back
	task automatic send_query(input dd_query_t q);
		int unsigned gap;
		gap = 0;
		if (!back_to_back) begin
			if (burst_left == 0) begin
				gap        = $urandom_range(1, 12);
				burst_left = $urandom_range(1, 30);
			end else begin
				burst_left--;
			end
		end
		if (gap > 0) begin
			query_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		query       <= q;
		query_valid <= 1'b1;
		@(posedge clk);
		while (query_stall)
			@(posedge clk);
		sent_count++;
	endtask

	// hold off the sender until every answer is back
	task automatic wait_answers_drained();
		query_valid <= 1'b0;
		@(posedge clk);
		while (due_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// calendar corners, invalid dates, include flag and saturation
	task automatic test_calendar_edges();
		send_query(make_query(1, 1, 1, 31, 12, 9999, 1'b0));
		send_query(make_query(31, 12, 9999, 1, 1, 1, 1'b1));
		send_query(make_query(15, 6, 2010, 15, 6, 2010, 1'b0));
		send_query(make_query(15, 6, 2010, 15, 6, 2010, 1'b1));
		send_query(make_query(1, 1, 1, 1, 1, 1, 1'b1));
		send_query(make_query(29, 2, 2000, 1, 3, 2000, 1'b0));
		send_query(make_query(29, 2, 1900, 1, 3, 1900, 1'b0));
		send_query(make_query(29, 2, 2024, 28, 2, 2023, 1'b0));
		send_query(make_query(1, 1, 2023, 29, 2, 2023, 1'b1));
		send_query(make_query(29, 2, 16000, 1, 1, 16001, 1'b0));
		send_query(make_query(2, 1, 2020, 1, 1, 2020, 1'b1));
		send_query(make_query(10, 0, 2000, 10, 5, 2000, 1'b0));
		send_query(make_query(10, 5, 2000, 10, 13, 2000, 1'b0));
		send_query(make_query(31, 15, 16383, 1, 1, 1, 1'b1));
		send_query(make_query(0, 3, 1999, 1, 3, 1999, 1'b0));
		send_query(make_query(1, 3, 1999, 0, 3, 1999, 1'b1));
		send_query(make_query(31, 4, 2001, 1, 5, 2001, 1'b0));
		send_query(make_query(1, 5, 2001, 31, 11, 2001, 1'b0));
		// year zero is a leap year; wide spans saturate both ways
		send_query(make_query(29, 2, 0, 31, 12, 16383, 1'b0));
		send_query(make_query(31, 12, 16383, 1, 1, 0, 1'b1));
		send_query(make_query(31, 12, 16383, 31, 12, 16383, 1'b0));
		send_query(make_query(1, 1, 0, 31, 12, 0, 1'b1));
		send_query(make_query(31, 1, 1, 31, 12, 9999, 1'b1));
		wait_answers_drained();
	endtask

	// well-formed dates in 1..9999, with nearby pairs and a run without gaps
	task automatic test_valid_dates();
		int unsigned sd, sm, sy, ed, em, ey;
		int unsigned ylo, yhi;
		for (int unsigned i = 0; i < N_VALID; i++) begin
			back_to_back = (i < 150);
			pick_date(1, 9999, sd, sm, sy);
			case ($urandom_range(0, 3))
				0: begin
					ylo = (sy > 1) ? sy - 1 : 1;
					yhi = (sy < 9999) ? sy + 1 : 9999;
					pick_date(ylo, yhi, ed, em, ey);
				end
				1: pick_date(sy, sy, ed, em, ey);
				default: pick_date(1, 9999, ed, em, ey);
			endcase
			send_query(make_query(sd, sm, sy, ed, em, ey, $urandom_range(0, 1)));
			if (i == N_VALID / 2)
				wait_answers_drained();
		end
		back_to_back = 1'b0;
		wait_answers_drained();
	endtask

	// well-formed days and months over the full 14-bit year range
	task automatic test_wide_years();
		int unsigned sd, sm, sy, ed, em, ey;
		for (int unsigned i = 0; i < N_WIDE; i++) begin
			pick_date(0, 16383, sd, sm, sy);
			pick_date(0, 16383, ed, em, ey);
			send_query(make_query(sd, sm, sy, ed, em, ey, $urandom_range(0, 1)));
		end
		wait_answers_drained();
	endtask

	// raw noise and near-miss dates with one field just out of range
	task automatic test_bad_dates();
		logic [63:0] raw;
		dd_query_t   q;
		int unsigned sd, sm, sy, ed, em, ey;
		for (int unsigned i = 0; i < N_BAD; i++) begin
			if ($urandom_range(0, 1) == 0) begin
				raw = {$urandom(), $urandom()};
				q   = raw[$bits(dd_query_t)-1:0];
			end else begin
				pick_date(1, 9999, sd, sm, sy);
				pick_date(1, 9999, ed, em, ey);
				case ($urandom_range(0, 3))
					0: sd = days_in_month(sm, sy) + 1;
					1: ed = 0;
					2: sm = $urandom_range(13, 15);
					default: em = 0;
				endcase
				q = make_query(sd, sm, sy, ed, em, ey, $urandom_range(0, 1));
			end
			send_query(q);
		end
		wait_answers_drained();
	endtask

	// receiver stall pattern: segments of different stall behavior
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_span = $urandom_range(5, 60);
		end else begin
			stall_span--;
		end
		case (stall_mode)
			STALL_NONE: answer_stall <= 1'b0;
			STALL_HALF: answer_stall <= ($urandom_range(0, 1) == 1);
			STALL_RARE: answer_stall <= ($urandom_range(0, 7) == 0);
			default:    answer_stall <= ((stall_span % 20) < 12);
		endcase
	end

	// record accepted queries and check accepted answers
	always @(posedge clk) begin
		due_answer_t du;
		if (query_valid && !query_stall) begin
			du.q = query;
			du.a = day_count_answer(query);
			due_answers.push_back(du);
		end
		if (answer_valid && !answer_stall) begin
			answer_count++;
			if (due_answers.size() == 0) begin
				error_count++;
				$display("%0t: unexpected answer, day_difference %0d invalid_date %0b",
					$time, answer.day_difference, answer.invalid_date);
			end else begin
				du = due_answers.pop_front();
				if (du.a.invalid_date)
					invalid_count++;
				else if (du.a.day_difference == MAX_MAG || du.a.day_difference == -MAX_MAG)
					saturated_count++;
				if (!du.a.invalid_date && du.a.day_difference < 0)
					negative_count++;
				if (answer.day_difference !== du.a.day_difference) begin
					error_count++;
					$display("%0t: day_difference mismatch for query %h, expected %0d, got %0d",
						$time, du.q, du.a.day_difference, answer.day_difference);
				end
				if (answer.invalid_date !== du.a.invalid_date) begin
					error_count++;
					$display("%0t: invalid_date mismatch for query %h, expected %0b, got %0b",
						$time, du.q, du.a.invalid_date, answer.invalid_date);
				end
			end
		end
	end

	// run limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("%0t: timeout with %0d answers outstanding", $time, due_answers.size());
		$display("tb_date_difference_in_days NOT OK");
		$finish;
	end

	// main sequence
	initial begin
		error_count     = 0;
		sent_count      = 0;
		answer_count    = 0;
		invalid_count   = 0;
		saturated_count = 0;
		negative_count  = 0;
		burst_left      = 0;
		back_to_back    = 1'b0;
		stall_mode      = STALL_NONE;
		stall_span      = 0;
		arst_n          <= 1'b0;
		query_valid     <= 1'b0;
		query           <= '0;
		answer_stall    <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_calendar_edges();
		test_valid_dates();
		test_wide_years();
		test_bad_dates();

		$display("Sent %0d queries, checked %0d answers: %0d invalid, %0d negative, %0d saturated.",
			sent_count, answer_count, invalid_count, negative_count, saturated_count);
		if (error_count == 0) begin
			$display("tb_date_difference_in_days OK");
		end else begin
			$display("%0d mismatches found", error_count);
			$display("tb_date_difference_in_days NOT OK");
		end
		$finish;
	end

endmodule
